/* hdl/tns_pkg.sv */
// tns_pkg: shared widths, operation codes, lane control struct and weight decode
// for the threshold network step block. No dependencies.
`default_nettype none

package tns_pkg;

  // payload widths fixed by the item format
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned WGT_W       = 2;
  localparam int unsigned VEC_W       = 20;

  // default network size and sources summed per lane per cycle
  localparam int unsigned NEURONS_DEF = 20;
  localparam int unsigned GROUP       = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // control broadcast from the sequencer to every lane
  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_src;
    logic [IDX_W-1:0]        wr_tgt;
    logic signed [WGT_W-1:0] wr_wgt;
    logic                    run;
    logic                    first;
    logic [IDX_W-1:0]        grp;
    logic [GROUP-1:0]        grp_act;
  } lane_ctl_t;

  // the unused pattern -2 saturates to -1
  function automatic logic signed [WGT_W-1:0] decode_weight(input logic [WGT_W-1:0] raw);
    logic signed [WGT_W-1:0] w;
    case (raw)
      2'b00:   w = 2'sb00;
      2'b01:   w = 2'sb01;
      default: w = 2'sb11;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/tns_if.sv */
// tns_in_if / tns_out_if: valid-ready channels for step and load beats and results.
// Depends on tns_pkg for the payload widths.
`default_nettype none

interface tns_in_if;
  import tns_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [IDX_W-1:0]        source_neuron;
  logic [IDX_W-1:0]        target_neuron;
  logic signed [WGT_W-1:0] weight_value;
  logic [VEC_W-1:0]        state_in;

  modport source (
    output valid, operation, source_neuron, target_neuron, weight_value, state_in,
    input  ready
  );
  modport sink (
    input  valid, operation, source_neuron, target_neuron, weight_value, state_in,
    output ready
  );
endinterface

interface tns_out_if;
  import tns_pkg::*;

  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] next_state;

  modport source (output valid, next_state, input ready);
  modport sink   (input valid, next_state, output ready);
endinterface

`default_nettype wire

/* hdl/threshold_network_step.sv */
// threshold_network_step: top level; sequencer, NEURONS weight lanes and the
// merge into the result register. Depends on tns_pkg, tns_if, tns_lane.
//
//   channel   dir  beat contents
//   in_chan   in   operation, source_neuron, target_neuron, weight_value, state_in
//   out_chan  out  next_state (one beat per step, none per load)
//
// A load beat is taken in S_IDLE without leaving it; the next beat can follow at once.
// A step beat runs through S_RUN, where each lane adds four sources a cycle into
// its accumulator, then S_FIN, where the lanes are merged into the result register.
// Reset (rst_n low, synchronous) clears all weights and the control state.
// New beats are taken while a result waits on out_chan; the merge cycle waits
// only if the result register is still full.
`default_nettype none

module threshold_network_step #(
  parameter int unsigned NEURONS = tns_pkg::NEURONS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tns_in_if.sink    in_chan,
  tns_out_if.source out_chan
);
  import tns_pkg::*;

  localparam int unsigned NGRP = (NEURONS + GROUP - 1) / GROUP;
  localparam int unsigned GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned PAD  = NGRP * GROUP;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [GW-1:0]    grp_r, grp_nxt;
  logic [PAD-1:0]   act_r, act_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VEC_W-1:0] out_data_r, out_data_nxt;

  logic [NEURONS-1:0] lane_fire;
  logic [VEC_W-1:0]   merged;
  logic               in_fire;
  logic               step_fire;
  logic               load_fire;
  logic               load_ok;
  logic               out_free;
  lane_ctl_t          ctl;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign step_fire     = in_fire && (in_chan.operation == OP_STEP);
  assign load_fire     = in_fire && (in_chan.operation == OP_LOAD);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign load_ok = ({1'b0, in_chan.source_neuron} < (IDX_W + 1)'(NEURONS)) &&
                   ({1'b0, in_chan.target_neuron} < (IDX_W + 1)'(NEURONS));

  // activity in source order, bits beyond the input field read as zero
  for (genvar s = 0; s < PAD; s++) begin : g_act
    if ((s < NEURONS) && (NEURONS - 1 - s < VEC_W)) begin : g_bit
      assign act_nxt[s] = in_chan.state_in[NEURONS-1-s];
    end else begin : g_zero
      assign act_nxt[s] = 1'b0;
    end
  end

  // lane control broadcast
  always_comb begin
    ctl         = '0;
    ctl.wr_en   = load_fire && load_ok;
    ctl.wr_src  = in_chan.source_neuron;
    ctl.wr_tgt  = in_chan.target_neuron;
    ctl.wr_wgt  = decode_weight(in_chan.weight_value);
    ctl.run     = (state_r == S_RUN);
    ctl.first   = (grp_r == '0);
    ctl.grp     = IDX_W'(grp_r);
    ctl.grp_act = act_r[grp_r * GROUP +: GROUP];
  end

  // one lane per target neuron
  for (genvar t = 0; t < NEURONS; t++) begin : g_lane
    tns_lane #(
      .NEURONS (NEURONS),
      .LANE    (t)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .fire  (lane_fire[t])
    );
  end

  // merge: neuron t lands at bit NEURONS-1-t, kept to the low field bits
  for (genvar b = 0; b < VEC_W; b++) begin : g_merge
    if (b < NEURONS) begin : g_bit
      assign merged[b] = lane_fire[NEURONS-1-b];
    end else begin : g_zero
      assign merged[b] = 1'b0;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (step_fire) begin
          state_nxt = S_RUN;
          grp_nxt   = '0;
        end
      end
      S_RUN: begin
        if (grp_r == GW'(NGRP - 1)) begin
          state_nxt = S_FIN;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = merged;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    if (step_fire) begin
      act_r <= act_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.next_state = out_data_r;

  // a step beat starts accumulation at the first group
  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_fire |=> (state_r == S_RUN) && (grp_r == '0))
    else $error("step beat did not start at the first group");

  // group counter stays within the lane groups
  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (grp_r <= GW'(NGRP - 1)))
    else $error("group counter out of range");

  // a result only appears from the merge cycle
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the merge cycle");

  // a load beat never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> !$rose(out_valid_r))
    else $error("load beat produced a result");

endmodule

`default_nettype wire

/* hdl/tns_lane.sv */
// tns_lane: one target neuron; holds its weight column and accumulates
// GROUP active sources per cycle while ctl.run is set. Depends on tns_pkg.
`default_nettype none

module tns_lane #(
  parameter int unsigned NEURONS = tns_pkg::NEURONS_DEF,
  parameter int unsigned LANE    = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tns_pkg::lane_ctl_t ctl,
  output logic                   fire
);
  import tns_pkg::*;

  localparam int unsigned SW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned ACC_W = $clog2(NEURONS + 1) + 1;

  logic signed [WGT_W-1:0] wgt_r [NEURONS];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] grp_sum;
  logic                    wr_hit;

  assign wr_hit = ctl.wr_en && (ctl.wr_tgt == IDX_W'(LANE));

  // weight column, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(NEURONS); i++) wgt_r[i] <= '0;
    end else if (wr_hit) begin
      wgt_r[ctl.wr_src[SW-1:0]] <= ctl.wr_wgt;
    end
  end

  // sum of weights from the active sources of this group
  always_comb begin
    logic [IDX_W-1:0] idx;
    grp_sum = '0;
    idx     = '0;
    for (int j = 0; j < int'(GROUP); j++) begin
      idx = IDX_W'(ctl.grp * GROUP) + IDX_W'(j);
      if (ctl.grp_act[j] && ({1'b0, idx} < (IDX_W + 1)'(NEURONS))) begin
        grp_sum = grp_sum + ACC_W'(wgt_r[idx[SW-1:0]]);
      end
    end
  end

  // accumulator restarts on the first group
  assign acc_nxt = ctl.first ? grp_sum : acc_r + grp_sum;

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      acc_r <= acc_nxt;
    end
  end

  // active next when the sum is not negative
  assign fire = ~acc_r[ACC_W-1];

endmodule

`default_nettype wire
